// ===== rtl/hsvrgb_pkg.sv =====
// Shared types and constants for the HSV to RGB pixel converter.
// Holds the pixel structs, internal stage structs and the reciprocal constants.
// No dependencies.
package hsvrgb_pkg;

	// field widths
	localparam int HUE_W = 16;
	localparam int SV_W  = 12;
	localparam int CH_W  = 8;

	// unsigned Q16 value in 0 .. 1.0
	localparam int Q_W   = 17;
	// wrapped hue angle, wide enough for 360 degrees at 8 fractional bits
	localparam int ANG_W = 17;
	// hue turn count, at most 91
	localparam int QUO_W = 7;
	localparam int SEC_W = 3;

	// dividend width of the Q16 scaling divides
	localparam int NUM_W = 23;

	// reciprocals: floor(n / d) = (n * RECIP) >> SHIFT, exact over the used range
	localparam int RCP_W = 24;
	localparam logic [RCP_W-1:0] RECIP_100  = 24'd10737419;
	localparam int               SHIFT_100  = 30;
	localparam logic [RCP_W-1:0] RECIP_60   = 24'd8947849;
	localparam int               SHIFT_60   = 29;
	localparam logic [16:0]      RECIP_360  = 17'd93207;
	localparam int               SHIFT_360  = 25;
	localparam logic [9:0]       RECIP_60S  = 10'd547;
	localparam int               SHIFT_60S  = 15;

	typedef logic [Q_W-1:0]   q16_t;
	typedef logic [ANG_W-1:0] ang_t;

	// 60-degree sector; the last code is hue exactly one full turn
	typedef enum logic [SEC_W-1:0] {
		SEC_RG   = 3'd0,
		SEC_GR   = 3'd1,
		SEC_GB   = 3'd2,
		SEC_BG   = 3'd3,
		SEC_BR   = 3'd4,
		SEC_RB   = 3'd5,
		SEC_WRAP = 3'd6
	} sector_t;

	typedef struct packed {
		logic signed [HUE_W-1:0] hue;
		logic signed [SV_W-1:0]  saturation;
		logic signed [SV_W-1:0]  brightness;
	} hsv_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            invalid;
	} rgb_t;

	// after normalization: value, chroma, wrapped hue
	typedef struct packed {
		logic valid;
		logic invalid;
		q16_t v;
		q16_t c;
		ang_t w;
	} norm_t;

	// after hue phase: sector, chroma, offset and X weight
	typedef struct packed {
		logic    valid;
		logic    invalid;
		sector_t sector;
		q16_t    c;
		q16_t    m;
		q16_t    factor;
	} phase_t;

endpackage

// ===== rtl/hsvrgb_norm.sv =====
// Front stages: range check, s and v to Q16, chroma product, hue wrap.
// Depends on hsvrgb_pkg. Two register stages (s1, s2).
module hsvrgb_norm import hsvrgb_pkg::*; #(
	parameter int FRAC_BITS = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  hsv_t  in_px,
	output norm_t out
);

	localparam int   PCT    = 100 << FRAC_BITS;
	localparam int   FULL   = 360 << FRAC_BITS;
	localparam ang_t FULL_A = ANG_W'(FULL);

	// stage 1 logic
	logic                      bad;
	logic [NUM_W-1:0]          sat_num;
	logic [NUM_W-1:0]          val_num;
	logic [NUM_W+RCP_W-1:0]    sat_prod;
	logic [NUM_W+RCP_W-1:0]    val_prod;
	logic [HUE_W-1:0]          hue_bits;
	logic [HUE_W-1:0]          abs_h;
	logic [HUE_W-1:0]          turns_in;
	logic [HUE_W+16:0]         turns_prod;
	logic                      hpos;

	// stage 1 registers
	logic             valid_s1;
	logic             invalid_s1;
	q16_t             s_s1;
	q16_t             v_s1;
	logic [QUO_W-1:0] q_s1;
	logic [HUE_W-1:0] abs_h_s1;
	logic             hpos_s1;

	// stage 2 logic
	logic [2*Q_W-1:0] c_prod;
	ang_t             qd;
	ang_t             rem;
	ang_t             w_next;

	// stage 2 registers
	logic valid_s2;
	logic invalid_s2;
	q16_t v_s2;
	q16_t c_s2;
	ang_t w_s2;

	// range check and reciprocal products
	always_comb begin
		bad = (in_px.saturation < 0) || (int'(in_px.saturation) > PCT) ||
			(in_px.brightness < 0) || (int'(in_px.brightness) > PCT);
		sat_num  = NUM_W'({in_px.saturation[SV_W-2:0], 16'b0} >> FRAC_BITS);
		val_num  = NUM_W'({in_px.brightness[SV_W-2:0], 16'b0} >> FRAC_BITS);
		sat_prod = sat_num * RECIP_100;
		val_prod = val_num * RECIP_100;
		hue_bits = in_px.hue;
		abs_h    = hue_bits[HUE_W-1] ? (~hue_bits + 1'b1) : hue_bits;
		hpos     = !hue_bits[HUE_W-1] && (hue_bits != '0);
		turns_in = abs_h >> FRAC_BITS;
		turns_prod = turns_in * RECIP_360;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		invalid_s1 <= bad;
		s_s1       <= sat_prod[SHIFT_100 +: Q_W];
		v_s1       <= val_prod[SHIFT_100 +: Q_W];
		q_s1       <= turns_prod[SHIFT_360 +: QUO_W];
		abs_h_s1   <= abs_h;
		hpos_s1    <= hpos;
	end

	// chroma product, hue remainder and wrap
	always_comb begin
		c_prod = s_s1 * v_s1;
		qd     = ANG_W'(q_s1) * FULL_A;
		rem    = ANG_W'(abs_h_s1) - qd;
		w_next = hpos_s1 ? rem : (FULL_A - rem);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		invalid_s2 <= invalid_s1;
		v_s2       <= v_s1;
		c_s2       <= c_prod[16 +: Q_W];
		w_s2       <= w_next;
	end

	assign out.valid   = valid_s2;
	assign out.invalid = invalid_s2;
	assign out.v       = v_s2;
	assign out.c       = c_s2;
	assign out.w       = w_s2;

endmodule

// ===== rtl/hsvrgb_phase.sv =====
// Hue phase stages: sector, offset m, position within the sector pair, X weight.
// Depends on hsvrgb_pkg. Four register stages (s3 .. s6).
module hsvrgb_phase import hsvrgb_pkg::*; #(
	parameter int FRAC_BITS = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  norm_t  in,
	output phase_t out
);

	localparam ang_t TWO_S60 = ANG_W'(120 << FRAC_BITS);

	// stage 3
	logic [8:0]       deg;
	logic [18:0]      sec_prod;
	logic             valid_s3;
	logic             invalid_s3;
	sector_t          sector_s3;
	q16_t             c_s3;
	q16_t             m_s3;
	ang_t             w_s3;

	// stage 4
	logic [SEC_W-1:0] sec_bits;
	ang_t             base;
	logic             valid_s4;
	logic             invalid_s4;
	sector_t          sector_s4;
	q16_t             c_s4;
	q16_t             m_s4;
	ang_t             u_s4;

	// stage 5
	logic [NUM_W-1:0]       f_num;
	logic [NUM_W+RCP_W-1:0] f_prod;
	logic                   valid_s5;
	logic                   invalid_s5;
	sector_t                sector_s5;
	q16_t                   c_s5;
	q16_t                   m_s5;
	q16_t                   f_s5;

	// stage 6
	q16_t    factor;
	logic    valid_s6;
	logic    invalid_s6;
	sector_t sector_s6;
	q16_t    c_s6;
	q16_t    m_s6;
	q16_t    factor_s6;

	// sector from whole degrees, offset m = v - C
	always_comb begin
		deg      = 9'(in.w >> FRAC_BITS);
		sec_prod = deg * RECIP_60S;
	end

	// position inside the 120-degree pair
	always_comb begin
		sec_bits = sector_s3;
		base     = ANG_W'(sec_bits[SEC_W-1:1]) * TWO_S60;
	end

	// Q16 fraction of 60 degrees
	always_comb begin
		f_num  = NUM_W'({u_s4, 16'b0} >> FRAC_BITS);
		f_prod = f_num * RECIP_60;
	end

	// weight 1 - |f - 1|: f below one stays, else 2 - f
	always_comb begin
		factor = f_s5[Q_W-1] ? (~f_s5 + 1'b1) : f_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s3 <= in.valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		invalid_s3 <= in.invalid;
		sector_s3  <= sector_t'(sec_prod[SHIFT_60S +: SEC_W]);
		c_s3       <= in.c;
		m_s3       <= in.v - in.c;
		w_s3       <= in.w;

		invalid_s4 <= invalid_s3;
		sector_s4  <= sector_s3;
		c_s4       <= c_s3;
		m_s4       <= m_s3;
		u_s4       <= w_s3 - base;

		invalid_s5 <= invalid_s4;
		sector_s5  <= sector_s4;
		c_s5       <= c_s4;
		m_s5       <= m_s4;
		f_s5       <= f_prod[SHIFT_60 +: Q_W];

		invalid_s6 <= invalid_s5;
		sector_s6  <= sector_s5;
		c_s6       <= c_s5;
		m_s6       <= m_s5;
		factor_s6  <= factor;
	end

	assign out.valid   = valid_s6;
	assign out.invalid = invalid_s6;
	assign out.sector  = sector_s6;
	assign out.c       = c_s6;
	assign out.m       = m_s6;
	assign out.factor  = factor_s6;

endmodule

// ===== rtl/hsvrgb_mix.sv =====
// Back stages: X component, channel order by sector, scale to 8 bits.
// Depends on hsvrgb_pkg. Three register stages (s7 .. s9), s9 drives the result.
module hsvrgb_mix import hsvrgb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  phase_t in,
	output logic   done,
	output rgb_t   rgb
);

	// stage 7
	logic [2*Q_W-1:0] x_prod;
	logic             valid_s7;
	logic             invalid_s7;
	sector_t          sector_s7;
	q16_t             c_s7;
	q16_t             m_s7;
	q16_t             x_s7;

	// stage 8
	q16_t r_comp;
	q16_t g_comp;
	q16_t b_comp;
	logic valid_s8;
	logic invalid_s8;
	q16_t r_s8;
	q16_t g_s8;
	q16_t b_s8;

	// stage 9
	logic [Q_W+7:0]  r_scaled;
	logic [Q_W+7:0]  g_scaled;
	logic [Q_W+7:0]  b_scaled;
	logic            valid_s9;
	rgb_t            rgb_s9;

	// X = C * weight
	assign x_prod = in.c * in.factor;

	// channel order by sector
	always_comb begin
		r_comp = '0;
		g_comp = '0;
		b_comp = '0;
		case (sector_s7)
			SEC_RG: begin
				r_comp = c_s7;
				g_comp = x_s7;
			end
			SEC_GR: begin
				r_comp = x_s7;
				g_comp = c_s7;
			end
			SEC_GB: begin
				g_comp = c_s7;
				b_comp = x_s7;
			end
			SEC_BG: begin
				g_comp = x_s7;
				b_comp = c_s7;
			end
			SEC_BR: begin
				r_comp = x_s7;
				b_comp = c_s7;
			end
			default: begin
				r_comp = c_s7;
				b_comp = x_s7;
			end
		endcase
	end

	// times 255 as shift and subtract
	always_comb begin
		r_scaled = {r_s8, 8'b0} - (Q_W+8)'(r_s8);
		g_scaled = {g_s8, 8'b0} - (Q_W+8)'(g_s8);
		b_scaled = {b_s8, 8'b0} - (Q_W+8)'(b_s8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			valid_s7 <= in.valid;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		invalid_s7 <= in.invalid;
		sector_s7  <= in.sector;
		c_s7       <= in.c;
		m_s7       <= in.m;
		x_s7       <= x_prod[16 +: Q_W];

		// out-of-range input gives black
		invalid_s8 <= invalid_s7;
		r_s8       <= invalid_s7 ? '0 : (r_comp + m_s7);
		g_s8       <= invalid_s7 ? '0 : (g_comp + m_s7);
		b_s8       <= invalid_s7 ? '0 : (b_comp + m_s7);

		rgb_s9.red     <= r_scaled[16 +: CH_W];
		rgb_s9.green   <= g_scaled[16 +: CH_W];
		rgb_s9.blue    <= b_scaled[16 +: CH_W];
		rgb_s9.invalid <= invalid_s8;
	end

	assign done = valid_s9;
	assign rgb  = rgb_s9;

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB pixel converter, top level.
// Depends on hsvrgb_pkg, hsvrgb_norm, hsvrgb_phase and hsvrgb_mix.
//
// Usage:
//   Drive a pixel on hsv and raise start; the item is taken at that clock
//   edge. busy is always low, so a new item may be given on every cycle.
//   Each item gives one result: done is high for exactly one cycle with
//   the color on rgb. Throughput is one item per clock; the latency is
//   set by the nine register stages (two normalize, four hue phase,
//   three mix), none of which has more than one multiply in series on
//   its longest path.
//   Saturation or brightness outside 0 .. 100 percent gives black with
//   rgb.invalid set. Hue of any value is wrapped into one turn.
//   The receiver cannot stall; results must be taken when done is high.
//   Reset (arst_n low) clears all stage valid bits, dropping items in
//   flight; no result appears until a new item is taken.
module hsv_to_rgb_converter import hsvrgb_pkg::*; #(
	parameter int FRAC_BITS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  hsv_t hsv,
	output logic done,
	output rgb_t rgb
);

	norm_t  norm;
	phase_t phase;

	// pipeline never blocks
	assign busy = 1'b0;

	hsvrgb_norm #(
		.FRAC_BITS(FRAC_BITS)
	) u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(start),
		.in_px   (hsv),
		.out     (norm)
	);

	hsvrgb_phase #(
		.FRAC_BITS(FRAC_BITS)
	) u_phase (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (norm),
		.out   (phase)
	);

	hsvrgb_mix u_mix (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (phase),
		.done  (done),
		.rgb   (rgb)
	);

endmodule
